[hw/rtl/qts_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qts_pkg
// Shared types and constants of the quantum task scheduler.
// ----------------------------------------------------------------------------
package qts_pkg;

  localparam int SEQ_BITS   = 17;
  localparam int COUNT_BITS = 7;
  localparam int TICK_BITS  = 16;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_IO_DONE = 3'd1,
    OP_TICK    = 3'd2,
    OP_TO_IO   = 3'd3,
    OP_END     = 3'd4
  } op_t;

  localparam logic CFG_MODE    = 1'b0;
  localparam logic CFG_QUANTUM = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input word, run event
    logic scan_start; // clear best candidate, start at slot 0
    logic scan_step;  // compare one slot
    logic finish;     // commit dispatch, produce result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
  } dp_stat_t;

endpackage
`default_nettype wire

[hw/rtl/qts_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qts_ctrl
// Sequencer: accept word, run event, scan store, deliver result.
// ----------------------------------------------------------------------------
module qts_ctrl
  import qts_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EVENT = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DONE  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EVENT;
        end
      end
      S_EVENT: begin
        cmd.scan_start = 1'b1;
        state_next     = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_next = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule
`default_nettype wire

[hw/rtl/qts_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qts_datapath
// Task stores, running slot, counters and the sequential best-task scan.
// ----------------------------------------------------------------------------
module qts_datapath
  import qts_pkg::*;
#(
  parameter int STORE_DEPTH = 16,
  parameter int ID_BITS     = 16,
  parameter int PRIO_BITS   = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dp_cmd_t               cmd,
  output dp_stat_t                   stat,
  input  wire logic                  cfg_mode,
  input  wire logic [TICK_BITS-1:0]  cfg_quantum,
  input  wire logic [2:0]            operation,
  input  wire logic [ID_BITS-1:0]    task_id,
  input  wire logic [PRIO_BITS-1:0]  priority_req,
  output logic                       dispatch_valid,
  output logic [ID_BITS-1:0]         dispatch_id,
  output logic                       suspend_valid,
  output logic [ID_BITS-1:0]         suspend_id,
  output logic                       busy_res,
  output logic [COUNT_BITS-1:0]      live_tasks,
  output logic [COUNT_BITS-1:0]      waiting_tasks,
  output logic                       dropped
);

  localparam int IDX_BITS = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
    logic [SEQ_BITS-1:0]  seq;
  } entry_t;

  // two banks; bank_sel names the one acting as active store
  entry_t store_a [STORE_DEPTH];
  entry_t store_b [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid_a, valid_b;
  logic bank_sel;

  logic [ID_BITS-1:0]   run_id;
  logic [PRIO_BITS-1:0] run_prio;
  logic                 run_flag;
  logic [TICK_BITS-1:0] tick_count;
  logic [COUNT_BITS-1:0] live_count, waiting_count;
  logic [SEQ_BITS-1:0]  seq;

  logic [IDX_BITS-1:0]  scan_idx;
  logic                 best_found;
  logic [IDX_BITS-1:0]  best_idx;
  logic [PRIO_BITS-1:0] best_prio;
  logic [SEQ_BITS-1:0]  best_age;
  logic                 need_dispatch;

  logic [STORE_DEPTH-1:0] act_valid, exp_valid;
  assign act_valid = bank_sel ? valid_b : valid_a;
  assign exp_valid = bank_sel ? valid_a : valid_b;

  // event decode
  op_t op;
  assign op = op_t'(operation);
  logic [TICK_BITS-1:0] quantum, tick_inc;
  assign quantum  = (cfg_quantum == '0) ? TICK_BITS'(1) : cfg_quantum;
  assign tick_inc = tick_count + TICK_BITS'(1);

  logic put_en, put_to_exp, put_ok;
  logic [ID_BITS-1:0]   put_id;
  logic [PRIO_BITS-1:0] put_prio;
  logic                 expire;
  logic [STORE_DEPTH-1:0] tgt_valid;
  logic [IDX_BITS-1:0]  free_idx;
  logic                 free_any;

  always_comb begin
    put_en = 1'b0;
    put_to_exp = 1'b0;
    put_id = task_id;
    put_prio = priority_req;
    expire = 1'b0;
    case (op)
      OP_ADD, OP_IO_DONE: put_en = 1'b1;
      OP_TICK: begin
        if (run_flag && tick_inc >= quantum) begin
          expire = 1'b1;
          put_en = 1'b1;
          put_to_exp = cfg_mode;
          put_id = run_id;
          put_prio = run_prio;
        end
      end
      default: ;
    endcase
  end

  assign tgt_valid = put_to_exp ? exp_valid : act_valid;

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = STORE_DEPTH - 1; i >= 0; i--) begin
      if (!tgt_valid[i]) begin
        free_any = 1'b1;
        free_idx = IDX_BITS'(i);
      end
    end
  end
  assign put_ok = put_en && free_any;

  logic put_bank;
  assign put_bank = put_to_exp ? ~bank_sel : bank_sel;

  // scan compare on the active bank
  entry_t cand;
  logic   cand_valid;
  logic [PRIO_BITS-1:0] cand_prio;
  logic [SEQ_BITS-1:0]  cand_age;
  logic                 cand_better;
  assign cand       = bank_sel ? store_b[scan_idx] : store_a[scan_idx];
  assign cand_valid = act_valid[scan_idx];
  assign cand_prio  = cfg_mode ? cand.prio : '0;
  assign cand_age   = seq - cand.seq;
  assign cand_better = cand_valid && (!best_found || cand_prio > best_prio ||
                       (cand_prio == best_prio && cand_age > best_age));
  assign stat.scan_last = (32'(scan_idx) == STORE_DEPTH - 1);

  entry_t best_entry;
  assign best_entry = bank_sel ? store_b[best_idx] : store_a[best_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a        <= '0;
      valid_b        <= '0;
      bank_sel       <= 1'b0;
      run_flag       <= 1'b0;
      run_id         <= '0;
      run_prio       <= '0;
      tick_count     <= '0;
      live_count     <= '0;
      waiting_count  <= '0;
      seq            <= '0;
      scan_idx       <= '0;
      best_found     <= 1'b0;
      need_dispatch  <= 1'b0;
      dispatch_valid <= 1'b0;
      suspend_valid  <= 1'b0;
      dropped        <= 1'b0;
    end else begin
      if (cmd.load) begin
        dispatch_valid <= 1'b0;
        dispatch_id    <= '0;
        suspend_valid  <= expire;
        suspend_id     <= expire ? run_id : '0;
        dropped        <= put_en && !free_any;
        if (put_ok) begin
          if (put_bank) begin
            store_b[free_idx] <= '{id: put_id, prio: put_prio, seq: seq};
            valid_b[free_idx] <= 1'b1;
          end else begin
            store_a[free_idx] <= '{id: put_id, prio: put_prio, seq: seq};
            valid_a[free_idx] <= 1'b1;
          end
          seq <= seq + SEQ_BITS'(1);
        end
        case (op)
          OP_ADD: if (put_ok && live_count != COUNT_MAX) live_count <= live_count + 1'b1;
          OP_IO_DONE: if (waiting_count != '0) waiting_count <= waiting_count - 1'b1;
          OP_TICK: begin
            if (run_flag) begin
              if (expire) begin
                run_flag   <= 1'b0;
                tick_count <= '0;
              end else begin
                tick_count <= tick_inc;
              end
            end
          end
          OP_TO_IO: begin
            if (run_flag) begin
              run_flag   <= 1'b0;
              tick_count <= '0;
              if (waiting_count != COUNT_MAX) waiting_count <= waiting_count + 1'b1;
            end
          end
          OP_END: begin
            if (run_flag) begin
              run_flag   <= 1'b0;
              tick_count <= '0;
              if (live_count != '0) live_count <= live_count - 1'b1;
            end
          end
          default: ;
        endcase
      end

      // swap when active is empty, then decide if a dispatch is due
      if (cmd.scan_start) begin
        if (act_valid == '0) bank_sel <= ~bank_sel;
        need_dispatch <= !run_flag;
        scan_idx      <= '0;
        best_found    <= 1'b0;
      end

      if (cmd.scan_step) begin
        if (cand_better) begin
          best_found <= 1'b1;
          best_idx   <= scan_idx;
          best_prio  <= cand_prio;
          best_age   <= cand_age;
        end
        if (!stat.scan_last) scan_idx <= scan_idx + IDX_BITS'(1);
      end

      if (cmd.finish && need_dispatch && best_found) begin
        run_flag       <= 1'b1;
        run_id         <= best_entry.id;
        run_prio       <= best_entry.prio;
        tick_count     <= '0;
        dispatch_valid <= 1'b1;
        dispatch_id    <= best_entry.id;
        if (bank_sel) valid_b[best_idx] <= 1'b0;
        else          valid_a[best_idx] <= 1'b0;
      end
    end
  end

  assign busy_res      = run_flag;
  assign live_tasks    = live_count;
  assign waiting_tasks = waiting_count;

endmodule
`default_nettype wire

[hw/rtl/quantum_task_scheduler.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// quantum_task_scheduler
// Event-driven task scheduler with active/expired stores and a running slot.
// ----------------------------------------------------------------------------
// In the cycle after an event word is accepted, the store swap is handled. The
// dispatch scan then walks the active store one slot per cycle, and the S_DONE
// state commits the dispatch. The result word is then presented in S_OUT and
// held until taken. The next event is accepted in the cycle after the result
// is taken, so a new event is not accepted while an earlier one is still in
// flight. Write configuration only while no event is in flight.
module quantum_task_scheduler
  import qts_pkg::*;
#(
  parameter int STORE_DEPTH = 16,
  parameter int ID_BITS     = 16,
  parameter int PRIO_BITS   = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [15:0]           cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [2:0]            operation,
  input  wire logic [ID_BITS-1:0]    task_id,
  input  wire logic [PRIO_BITS-1:0]  priority_req,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       dispatch_valid,
  output logic [ID_BITS-1:0]         dispatch_id,
  output logic                       suspend_valid,
  output logic [ID_BITS-1:0]         suspend_id,
  output logic                       busy_res,
  output logic [COUNT_BITS-1:0]      live_tasks,
  output logic [COUNT_BITS-1:0]      waiting_tasks,
  output logic                       dropped
);

  logic                 scheduling_mode;
  logic [TICK_BITS-1:0] quantum_ticks;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      scheduling_mode <= 1'b0;
      quantum_ticks   <= TICK_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:    scheduling_mode <= cfg_data[0];
        CFG_QUANTUM: quantum_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  qts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  qts_datapath #(
    .STORE_DEPTH (STORE_DEPTH),
    .ID_BITS     (ID_BITS),
    .PRIO_BITS   (PRIO_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_mode       (scheduling_mode),
    .cfg_quantum    (quantum_ticks),
    .operation      (operation),
    .task_id        (task_id),
    .priority_req   (priority_req),
    .dispatch_valid (dispatch_valid),
    .dispatch_id    (dispatch_id),
    .suspend_valid  (suspend_valid),
    .suspend_id     (suspend_id),
    .busy_res       (busy_res),
    .live_tasks     (live_tasks),
    .waiting_tasks  (waiting_tasks),
    .dropped        (dropped)
  );

endmodule
`default_nettype wire

[test/quantum_task_scheduler_tb.sv]
// ----------------------------------------------------------------------------
// quantum_task_scheduler_tb
// Drives scheduler events with random gaps and back-pressure, predicts the
// dispatch, suspend, count and drop outcome of each event, compares in order.
// ----------------------------------------------------------------------------
module quantum_task_scheduler_tb
  import qts_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int LIMIT = 2000000;
  localparam int QDEPTH = 16;

  typedef struct packed {
    logic        dv;
    logic [15:0] did;
    logic        sv;
    logic [15:0] sid;
    logic        busy;
    logic [6:0]  live;
    logic [6:0]  waiting;
    logic        drop;
  } sched_out_t;

  typedef struct {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [16:0] seq;
  } slot_t;

  class sched_scoreboard;
    logic        prio_mode;
    logic [15:0] quantum;
    slot_t       act[DEPTH];
    logic        act_v[DEPTH];
    slot_t       exp[DEPTH];
    logic        exp_v[DEPTH];
    logic [15:0] run_id;
    logic [7:0]  run_prio;
    logic        running;
    logic [15:0] ticks;
    logic [6:0]  live;
    logic [6:0]  waiting;
    logic [16:0] seq_ctr;
    sched_out_t  want_q[QDEPTH];
    int          wr_ptr;
    int          rd_ptr;
    int          errors;
    int          checked;
    int          dispatches;
    int          suspends;
    int          drops;

    function new();
      prio_mode = 0;
      quantum = 1;
      running = 0;
      ticks = 0;
      live = 0;
      waiting = 0;
      seq_ctr = 0;
      run_id = 0;
      run_prio = 0;
      wr_ptr = 0;
      rd_ptr = 0;
      for (int i = 0; i < DEPTH; i++) begin
        act_v[i] = 0;
        exp_v[i] = 0;
      end
    endfunction

    function int outstanding();
      return wr_ptr - rd_ptr;
    endfunction

    function void add_want(sched_out_t r);
      want_q[wr_ptr % QDEPTH] = r;
      wr_ptr++;
    endfunction

    function sched_out_t take_want();
      sched_out_t r;
      r = want_q[rd_ptr % QDEPTH];
      rd_ptr++;
      return r;
    endfunction

    function bit enqueue(bit to_expired, logic [15:0] id, logic [7:0] pr);
      for (int i = 0; i < DEPTH; i++) begin
        if (!(to_expired ? exp_v[i] : act_v[i])) begin
          if (to_expired) begin
            exp[i] = '{id, pr, seq_ctr};
            exp_v[i] = 1;
          end else begin
            act[i] = '{id, pr, seq_ctr};
            act_v[i] = 1;
          end
          seq_ctr++;
          return 1;
        end
      end
      return 0;
    endfunction

    function void note_event(op_t op, logic [15:0] id, logic [7:0] pr);
      sched_out_t r;
      bit any;
      int best;
      logic [16:0] age, best_age;
      logic [7:0] p, best_p;
      slot_t ts;
      logic tv;
      logic [15:0] q;
      r = '0;
      case (op)
        OP_ADD: begin
          if (enqueue(0, id, pr)) begin
            if (live != 7'd127) live++;
          end else r.drop = 1;
        end
        OP_IO_DONE: begin
          if (!enqueue(0, id, pr)) r.drop = 1;
          if (waiting != 0) waiting--;
        end
        OP_TICK: begin
          if (running) begin
            q = (quantum == 0) ? 16'd1 : quantum;
            ticks++;
            if (ticks >= q) begin
              r.sv = 1;
              r.sid = run_id;
              if (!enqueue(prio_mode, run_id, run_prio)) r.drop = 1;
              running = 0;
              ticks = 0;
            end
          end
        end
        OP_TO_IO: begin
          if (running) begin
            running = 0;
            ticks = 0;
            if (waiting != 7'd127) waiting++;
          end
        end
        OP_END: begin
          if (running) begin
            running = 0;
            ticks = 0;
            if (live != 0) live--;
          end
        end
        default: ;
      endcase
      any = 0;
      for (int i = 0; i < DEPTH; i++) any |= act_v[i];
      if (!any) begin
        for (int i = 0; i < DEPTH; i++) begin
          ts = act[i]; tv = act_v[i];
          act[i] = exp[i]; act_v[i] = exp_v[i];
          exp[i] = ts; exp_v[i] = tv;
        end
      end
      if (!running) begin
        best = -1;
        best_age = 0;
        best_p = 0;
        for (int i = 0; i < DEPTH; i++) begin
          if (act_v[i]) begin
            age = seq_ctr - act[i].seq;
            p = prio_mode ? act[i].prio : 8'd0;
            if (best < 0 || p > best_p || (p == best_p && age > best_age)) begin
              best = i; best_age = age; best_p = p;
            end
          end
        end
        if (best >= 0) begin
          run_id = act[best].id;
          run_prio = act[best].prio;
          running = 1;
          ticks = 0;
          act_v[best] = 0;
          r.dv = 1;
          r.did = run_id;
        end
      end
      r.busy = running;
      r.live = live;
      r.waiting = waiting;
      add_want(r);
    endfunction

    task report(string what, int got, int want);
      $display("mismatch #%0d %s: got %0h want %0h", checked, what, got, want);
      errors++;
    endtask

    task check_result(sched_out_t got);
      sched_out_t w;
      if (outstanding() == 0) begin
        report("result word with nothing pending", 1, 0);
        return;
      end
      w = take_want();
      if (got.dv !== w.dv) report("dispatch_valid", got.dv, w.dv);
      if (got.did !== w.did) report("dispatch_id", got.did, w.did);
      if (got.sv !== w.sv) report("suspend_valid", got.sv, w.sv);
      if (got.sid !== w.sid) report("suspend_id", got.sid, w.sid);
      if (got.busy !== w.busy) report("busy_res", got.busy, w.busy);
      if (got.live !== w.live) report("live_tasks", got.live, w.live);
      if (got.waiting !== w.waiting) report("waiting_tasks", got.waiting, w.waiting);
      if (got.drop !== w.drop) report("dropped", got.drop, w.drop);
      checked++;
      dispatches += w.dv;
      suspends += w.sv;
      drops += w.drop;
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic        cfg_index = CFG_MODE;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  operation = '0;
  logic [15:0] task_id = '0;
  logic [7:0]  priority_req = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic        dispatch_valid, suspend_valid, busy_res, dropped;
  logic [15:0] dispatch_id, suspend_id;
  logic [6:0]  live_tasks, waiting_tasks;

  sched_scoreboard sb = new();
  int cycles = 0;

  quantum_task_scheduler u_top (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .operation, .task_id, .priority_req,
    .out_valid, .out_ready,
    .dispatch_valid, .dispatch_id, .suspend_valid, .suspend_id,
    .busy_res, .live_tasks, .waiting_tasks, .dropped
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[quantum_task_scheduler] ERROR");
      $finish;
    end
  end

  // result side: random stalls, check on each accepted word
  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result('{dispatch_valid, dispatch_id, suspend_valid, suspend_id,
                        busy_res, live_tasks, waiting_tasks, dropped});
    end
  end

  task write_reg(logic idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_MODE) sb.prio_mode = val[0];
    else sb.quantum = val;
    @(posedge clk);
  endtask

  // drop valid, then hold until every expected word has come back
  task drain();
    in_valid <= 0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task send_word(logic [2:0] op, logic [15:0] id, logic [7:0] pr, int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    operation <= op;
    task_id <= id;
    priority_req <= pr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_event(op_t'(op), id, pr);
  endtask

  task send_random(int n, bit busy_burst);
    int r;
    logic [2:0] op;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 30) op = OP_ADD;
      else if (r < 40) op = OP_IO_DONE;
      else if (r < 70) op = OP_TICK;
      else if (r < 82) op = OP_TO_IO;
      else if (r < 97) op = OP_END;
      else op = 3'($urandom_range(5, 7));
      send_word(op, 16'($urandom), 8'($urandom),
                busy_burst ? 0 : $urandom_range(0, 14));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: fill past full, extremes, every operation, unknown codes
    write_reg(CFG_MODE, 16'd1);
    write_reg(CFG_QUANTUM, 16'd0);
    send_word(OP_TICK, 16'hffff, 8'hff, 0);
    send_word(OP_END, 16'h0, 8'h0, 0);
    for (int k = 0; k < 18; k++)
      send_word(OP_ADD, (k == 0) ? 16'h0000 : 16'hffff - 16'(k),
                (k == 1) ? 8'hff : 8'(k % 3), 0);
    send_word(OP_IO_DONE, 16'h5a5a, 8'h80, 1);
    send_word(OP_TICK, 16'h0, 8'h0, 0);
    send_word(OP_TO_IO, 16'h0, 8'h0, 0);
    send_word(3'd5, 16'h1234, 8'h01, 0);
    send_word(3'd7, 16'h0, 8'h0, 0);
    drain();

    write_reg(CFG_MODE, 16'd0);
    write_reg(CFG_QUANTUM, 16'hffff);
    send_random(200, 0);
    drain();

    write_reg(CFG_QUANTUM, 16'd1);
    send_random(500, 0);
    send_random(60, 1);
    drain();

    write_reg(CFG_MODE, 16'd1);
    write_reg(CFG_QUANTUM, 16'd3);
    send_random(500, 0);
    drain();

    write_reg(CFG_MODE, 16'hfffe);
    write_reg(CFG_QUANTUM, 16'd2);
    send_random(500, 0);
    drain();

    $display("events checked %0d: dispatches %0d, suspends %0d, drops %0d",
             sb.checked, sb.dispatches, sb.suspends, sb.drops);
    $display("covered both modes, quantum 0/1/2/3/max, full stores, unknown codes");
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("[quantum_task_scheduler] OK");
    end else begin
      $display("[quantum_task_scheduler] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/qts_pkg.sv
hw/rtl/qts_ctrl.sv
hw/rtl/qts_datapath.sv
hw/rtl/quantum_task_scheduler.sv
test/quantum_task_scheduler_tb.sv
